>>> design/lidar_roi_avoid_mode_top_macros.svh
// Assertion macros shared by the lidar ROI avoid-mode design.
`ifndef LIDAR_ROI_AVOID_MODE_TOP_MACROS_SVH
`define LIDAR_ROI_AVOID_MODE_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LROM_ASSERT_IMPLY(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LROM_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/lrom_pkg.sv
// Types and constants shared by the lidar ROI avoid-mode design.
`timescale 1ns / 1ps
`default_nettype none
package lrom_pkg;

  // Width of each box tally.
  localparam int COUNT_W = 12;

  // Operation codes of an input word.
  localparam logic [1:0] OP_SCAN_START = 2'd0;
  localparam logic [1:0] OP_POINT      = 2'd1;
  localparam logic [1:0] OP_FRAME_END  = 2'd2;
  localparam logic [1:0] OP_TICK       = 2'd3;

  // Configuration register indexes.
  localparam logic [2:0] REG_DIST_LIMIT   = 3'd0;
  localparam logic [2:0] REG_FRONT_LENGTH = 3'd1;
  localparam logic [2:0] REG_FRONT_HALF_W = 3'd2;
  localparam logic [2:0] REG_SIDE_LENGTH  = 3'd3;
  localparam logic [2:0] REG_SIDE_WIDTH   = 3'd4;
  localparam logic [2:0] REG_BLOCK_COUNT  = 3'd5;
  localparam logic [2:0] REG_RELEASE_CNT  = 3'd6;
  localparam logic [2:0] REG_TIMEOUT      = 3'd7;

  // Reported mode codes.
  localparam logic [1:0] MODE_TRACK       = 2'd0;
  localparam logic [1:0] MODE_AVOID_LEFT  = 2'd1;
  localparam logic [1:0] MODE_AVOID_RIGHT = 2'd2;

  // Steering values in thousandths.
  localparam logic [9:0] STEER_NONE       = 10'd0;
  localparam logic [9:0] STEER_LEFT       = 10'd200;
  localparam logic [9:0] STEER_RIGHT      = 10'd800;
  localparam logic [9:0] STEER_HARD_RIGHT = 10'd1000;

  typedef enum logic [2:0] {
    MS_TRACK       = 3'b001,
    MS_AVOID_LEFT  = 3'b010,
    MS_AVOID_RIGHT = 3'b100
  } mode_state_t;

  typedef struct packed {
    logic [1:0]         operation;
    logic signed [15:0] point_x_cm;
    logic signed [15:0] point_y_cm;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [9:0]  steer_milli;
    logic [11:0] front_count;
    logic [11:0] left_count;
    logic [11:0] right_count;
  } out_word_t;

  typedef struct packed {
    logic [14:0] dist_limit_cm;
    logic [14:0] front_length_cm;
    logic [14:0] front_half_width_cm;
    logic [14:0] side_length_cm;
    logic [14:0] side_width_cm;
    logic [11:0] block_count;
    logic [11:0] release_count;
    logic [15:0] timeout_ticks;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    dist_limit_cm:       15'd250,
    front_length_cm:     15'd400,
    front_half_width_cm: 15'd100,
    side_length_cm:      15'd300,
    side_width_cm:       15'd120,
    block_count:         12'd3,
    release_count:       12'd1,
    timeout_ticks:       16'd250
  };

  // Classified word passed from the front end to the back end.
  typedef struct packed {
    logic [1:0] op;
    logic       hit_front;
    logic       hit_left;
    logic       hit_right;
  } cls_word_t;

endpackage
`default_nettype wire

>>> design/lrom_fifo.sv
// Small register-based first-in first-out queue.
`timescale 1ns / 1ps
`default_nettype none
module lrom_fifo #(
  parameter int W  = 8,
  parameter int AW = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);

  localparam int DEPTH = 1 << AW;

  logic [W-1:0]  mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]   count_r, count_nxt;
  logic          do_push, do_pop;

  assign full    = (count_r == (AW+1)'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule
`default_nettype wire

>>> design/lrom_front.sv
// Front end: accept input words, square and box-test points, classify.
`timescale 1ns / 1ps
`default_nettype none
module lrom_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  input  lrom_pkg::in_word_t   in_word,
  output logic                 in_full,
  input  lrom_pkg::cfg_t       cfg,
  output logic                 cls_push,
  output lrom_pkg::cls_word_t  cls_word,
  input  logic                 cls_full
);

  logic        s1_valid_r, s1_valid_nxt;
  logic [1:0]  s1_op_r;
  logic        s1_front_r, s1_left_r, s1_right_r;
  logic [30:0] s1_xx_r, s1_yy_r;
  logic [29:0] lim_sq_r;

  logic        advance, accept;
  logic [15:0] x_u, y_u, x_mag, y_mag;
  logic        x_fwd, in_front, in_left, in_right, side_x_ok;
  logic [31:0] dist_sq;
  logic        in_range;

  assign advance = !s1_valid_r || !cls_full;
  assign in_full = !advance;
  assign accept  = in_push && advance;

  // Box tests on the incoming point; edges are inclusive.
  always_comb begin
    x_u       = in_word.point_x_cm;
    y_u       = in_word.point_y_cm;
    x_mag     = x_u[15] ? (~x_u + 16'd1) : x_u;
    y_mag     = y_u[15] ? (~y_u + 16'd1) : y_u;
    x_fwd     = !x_u[15];
    side_x_ok = x_fwd && (x_u[14:0] <= cfg.side_length_cm);
    in_front  = x_fwd && (x_u[14:0] <= cfg.front_length_cm)
                && (y_mag <= {1'b0, cfg.front_half_width_cm});
    in_left   = side_x_ok && !y_u[15] && (y_u[14:0] <= cfg.side_width_cm);
    in_right  = side_x_ok && ((y_u == 16'd0)
                || (y_u[15] && (y_mag <= {1'b0, cfg.side_width_cm})));
  end

  assign s1_valid_nxt = advance ? in_push : s1_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lim_sq_r <= 30'(cfg.dist_limit_cm) * 30'(cfg.dist_limit_cm);
    if (accept) begin
      s1_op_r    <= in_word.operation;
      s1_front_r <= in_front;
      s1_left_r  <= in_left;
      s1_right_r <= in_right;
      s1_xx_r    <= 31'(x_mag) * 31'(x_mag);
      s1_yy_r    <= 31'(y_mag) * 31'(y_mag);
    end
  end

  assign dist_sq  = 32'(s1_xx_r) + 32'(s1_yy_r);
  assign in_range = (dist_sq <= 32'(lim_sq_r));

  assign cls_push           = s1_valid_r && !cls_full;
  assign cls_word.op        = s1_op_r;
  assign cls_word.hit_front = in_range && s1_front_r;
  assign cls_word.hit_left  = in_range && s1_left_r;
  assign cls_word.hit_right = in_range && s1_right_r;

endmodule
`default_nettype wire

>>> design/lrom_back.sv
// Back end: box tallies, avoid timer and the mode machine.
`timescale 1ns / 1ps
`default_nettype none
module lrom_back #(
  parameter int RELEASE_RUN_FRAMES = 3
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cls_valid,
  input  lrom_pkg::cls_word_t  cls_word,
  output logic                 cls_pop,
  input  lrom_pkg::cfg_t       cfg,
  output logic                 res_push,
  output lrom_pkg::out_word_t  res_word,
  input  logic                 res_full
);

  localparam logic [lrom_pkg::COUNT_W-1:0] CNT_MAX = '1;

  lrom_pkg::mode_state_t          mode_r, mode_nxt;
  logic [lrom_pkg::COUNT_W-1:0]   front_r, front_nxt;
  logic [lrom_pkg::COUNT_W-1:0]   left_r, left_nxt;
  logic [lrom_pkg::COUNT_W-1:0]   right_r, right_nxt;
  logic [7:0]                     run_r, run_nxt;
  logic [15:0]                    elapsed_r, elapsed_nxt;
  logic                           hr_r, hr_nxt;

  logic       take, fb, lb, rb, all_clear;
  logic [9:0] steer;
  logic [1:0] mode_code;

  assign take    = cls_valid && !((cls_word.op == lrom_pkg::OP_FRAME_END) && res_full);
  assign cls_pop = take;

  always_comb begin
    fb = 16'(front_r) >= 16'(cfg.block_count);
    lb = 16'(left_r) >= 16'(cfg.block_count);
    rb = 16'(right_r) >= 16'(cfg.block_count);
    all_clear = (16'(front_r) <= 16'(cfg.release_count))
                && (16'(left_r) <= 16'(cfg.release_count))
                && (16'(right_r) <= 16'(cfg.release_count));
  end

  always_comb begin
    mode_nxt    = mode_r;
    front_nxt   = front_r;
    left_nxt    = left_r;
    right_nxt   = right_r;
    run_nxt     = run_r;
    elapsed_nxt = elapsed_r;
    hr_nxt      = hr_r;
    res_push    = 1'b0;
    steer       = lrom_pkg::STEER_NONE;
    mode_code   = lrom_pkg::MODE_TRACK;
    if (take) begin
      case (cls_word.op)
        lrom_pkg::OP_SCAN_START: begin
          front_nxt = '0;
          left_nxt  = '0;
          right_nxt = '0;
        end
        lrom_pkg::OP_POINT: begin
          if (cls_word.hit_front && (front_r != CNT_MAX)) front_nxt = front_r + 1'b1;
          if (cls_word.hit_left && (left_r != CNT_MAX)) left_nxt = left_r + 1'b1;
          if (cls_word.hit_right && (right_r != CNT_MAX)) right_nxt = right_r + 1'b1;
        end
        lrom_pkg::OP_TICK: begin
          if (elapsed_r != 16'hFFFF) elapsed_nxt = elapsed_r + 16'd1;
        end
        lrom_pkg::OP_FRAME_END: begin
          res_push = 1'b1;
          case (mode_r)
            lrom_pkg::MS_TRACK: begin
              if (fb || lb || rb) begin
                mode_nxt    = (fb || lb) ? lrom_pkg::MS_AVOID_RIGHT : lrom_pkg::MS_AVOID_LEFT;
                hr_nxt      = fb;
                run_nxt     = 8'd0;
                elapsed_nxt = 16'd0;
              end
            end
            default: begin
              if (all_clear) begin
                run_nxt = (run_r == 8'hFF) ? run_r : run_r + 8'd1;
              end else begin
                run_nxt = 8'd0;
              end
              if ((run_nxt >= 8'(RELEASE_RUN_FRAMES)) || (elapsed_r >= cfg.timeout_ticks)) begin
                mode_nxt = lrom_pkg::MS_TRACK;
              end
            end
          endcase
          if (mode_nxt != lrom_pkg::MS_TRACK) begin
            if (hr_nxt) begin
              steer  = lrom_pkg::STEER_HARD_RIGHT;
              hr_nxt = 1'b0;
            end else if (mode_nxt == lrom_pkg::MS_AVOID_LEFT) begin
              steer = lrom_pkg::STEER_LEFT;
            end else begin
              steer = lrom_pkg::STEER_RIGHT;
            end
          end
          case (mode_nxt)
            lrom_pkg::MS_AVOID_LEFT:  mode_code = lrom_pkg::MODE_AVOID_LEFT;
            lrom_pkg::MS_AVOID_RIGHT: mode_code = lrom_pkg::MODE_AVOID_RIGHT;
            default:                  mode_code = lrom_pkg::MODE_TRACK;
          endcase
        end
        default: begin
        end
      endcase
    end
  end

  assign res_word.mode        = mode_code;
  assign res_word.steer_milli = steer;
  assign res_word.front_count = 12'(front_r);
  assign res_word.left_count  = 12'(left_r);
  assign res_word.right_count = 12'(right_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= lrom_pkg::MS_TRACK;
      front_r   <= '0;
      left_r    <= '0;
      right_r   <= '0;
      run_r     <= 8'd0;
      elapsed_r <= 16'd0;
      hr_r      <= 1'b0;
    end else begin
      mode_r    <= mode_nxt;
      front_r   <= front_nxt;
      left_r    <= left_nxt;
      right_r   <= right_nxt;
      run_r     <= run_nxt;
      elapsed_r <= elapsed_nxt;
      hr_r      <= hr_nxt;
    end
  end

endmodule
`default_nettype wire

>>> design/lidar_roi_avoid_mode_top.sv
// Top level of the lidar ROI obstacle counter with avoid-mode machine.
//
//   channel | ports                          | word taken at rising edge when
//   --------+--------------------------------+--------------------------------
//   input   | in_push, in_full, in_word      | in_push && !in_full
//   result  | out_pop, out_empty, out_word   | out_pop && !out_empty
//   config  | cfg_valid, cfg_ready, cfg_index| cfg_valid && cfg_ready
//           | cfg_data                       |
//
// One input word is taken every cycle when nothing downstream stalls.
// A word passes through the front stage register (squares and box tests), then
// waits in a four-entry queue until the back end applies it.
// Frame-end results wait in a four-entry result queue; a full result queue
// holds the back end, a full classify queue holds the front end.
// Reset empties both queues, zeroes tallies and timer, sets track, loads defaults.
`timescale 1ns / 1ps
`default_nettype none
`include "lidar_roi_avoid_mode_top_macros.svh"
module lidar_roi_avoid_mode_top #(
  parameter int RELEASE_RUN_FRAMES = 3
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // input queue side
  input  logic                 in_push,
  input  lrom_pkg::in_word_t   in_word,
  output logic                 in_full,
  // result queue side
  output logic                 out_empty,
  input  logic                 out_pop,
  output lrom_pkg::out_word_t  out_word,
  // configuration writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [2:0]           cfg_index,
  input  logic [15:0]          cfg_data
);

  localparam int CLS_W = $bits(lrom_pkg::cls_word_t);
  localparam int RES_W = $bits(lrom_pkg::out_word_t);

  lrom_pkg::cfg_t      cfg_r, cfg_nxt;
  lrom_pkg::cls_word_t cls_in, cls_out;
  lrom_pkg::out_word_t res_word;
  logic                cls_push, cls_full, cls_empty, cls_pop;
  logic                res_push, res_full;
  logic [CLS_W-1:0]    cls_rdata;
  logic [RES_W-1:0]    res_rdata;
  logic                steer_mode_ok;

  // Configuration registers: always ready, writes land at the edge.
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        lrom_pkg::REG_DIST_LIMIT:   cfg_nxt.dist_limit_cm       = cfg_data[14:0];
        lrom_pkg::REG_FRONT_LENGTH: cfg_nxt.front_length_cm     = cfg_data[14:0];
        lrom_pkg::REG_FRONT_HALF_W: cfg_nxt.front_half_width_cm = cfg_data[14:0];
        lrom_pkg::REG_SIDE_LENGTH:  cfg_nxt.side_length_cm      = cfg_data[14:0];
        lrom_pkg::REG_SIDE_WIDTH:   cfg_nxt.side_width_cm       = cfg_data[14:0];
        lrom_pkg::REG_BLOCK_COUNT:  cfg_nxt.block_count         = cfg_data[11:0];
        lrom_pkg::REG_RELEASE_CNT:  cfg_nxt.release_count       = cfg_data[11:0];
        lrom_pkg::REG_TIMEOUT:      cfg_nxt.timeout_ticks       = cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= lrom_pkg::CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Front end: take words, classify points against the boxes.
  lrom_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_word  (in_word),
    .in_full  (in_full),
    .cfg      (cfg_r),
    .cls_push (cls_push),
    .cls_word (cls_in),
    .cls_full (cls_full)
  );

  // Decoupling queue between classification and the state update.
  lrom_fifo #(.W(CLS_W), .AW(2)) u_cls_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cls_push),
    .wdata (cls_in),
    .full  (cls_full),
    .pop   (cls_pop),
    .rdata (cls_rdata),
    .empty (cls_empty)
  );

  assign cls_out = cls_rdata;

  // Back end: apply one word per cycle to tallies, timer and mode unless stalled.
  lrom_back #(
    .RELEASE_RUN_FRAMES (RELEASE_RUN_FRAMES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cls_valid (!cls_empty),
    .cls_word  (cls_out),
    .cls_pop   (cls_pop),
    .cfg       (cfg_r),
    .res_push  (res_push),
    .res_word  (res_word),
    .res_full  (res_full)
  );

  // Result queue: hold frame-end reports until the consumer pops them.
  lrom_fifo #(.W(RES_W), .AW(2)) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_word),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (res_rdata),
    .empty (out_empty)
  );

  assign out_word = res_rdata;

  // Track mode goes with zero steering, avoid modes with nonzero steering.
  assign steer_mode_ok = ((out_word.mode == lrom_pkg::MODE_TRACK)
                          == (out_word.steer_milli == lrom_pkg::STEER_NONE));

  // The front end never pushes into a full classify queue.
  `LROM_ASSERT_IMPLY(a_cls_no_overflow, clk, rst_n, cls_push, !cls_full, "classify queue overflow")

  // The back end never reports into a full result queue.
  `LROM_ASSERT_IMPLY(a_res_no_overflow, clk, rst_n, res_push, !res_full, "result queue overflow")

  // Steering is zero exactly when the reported mode is track.
  `LROM_ASSERT_IMPLY(a_steer_mode, clk, rst_n, !out_empty, steer_mode_ok, "steer and mode disagree")

  // A reported frame is visible on the result side in the next cycle.
  `LROM_ASSERT_NEXT(a_res_visible, clk, rst_n, res_push, !out_empty, "result lost after push")

endmodule
`default_nettype wire

>>> test/lidar_roi_avoid_mode_top_tb.sv
// Self-checking testbench for the lidar ROI obstacle counter and avoid-mode machine.
`timescale 1ns / 1ps
module lidar_roi_avoid_mode_top_tb;

  // Clear frames in a row that end an avoid episode (matches the DUT default).
  localparam int          CLEAR_RUN_TO_EXIT = 3;
  localparam logic [11:0] TALLY_MAX         = 12'hFFF;
  // Front stage, classify queue and back end together hold a handful of words;
  // wait well past that before touching registers or ending the run.
  localparam int          SETTLE_CYCLES     = 24;
  localparam int          WORDS_PER_PHASE   = 108;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_push   = 1'b0;
  lrom_pkg::in_word_t  in_word   = '0;
  logic                in_full;
  logic                out_empty;
  logic                out_pop   = 1'b0;
  lrom_pkg::out_word_t out_word;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [2:0]          cfg_index = '0;
  logic [15:0]         cfg_data  = '0;

  lidar_roi_avoid_mode_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_word   (in_word),
    .in_full   (in_full),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_word  (out_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Obstacle predictor: its own copy of the registers, tallies and mode machine.
  // ---------------------------------------------------------------------------
  lrom_pkg::cfg_t roi_cfg;
  logic [1:0]     mode_now;
  logic [11:0]    front_tally;
  logic [11:0]    left_tally;
  logic [11:0]    right_tally;
  logic [7:0]     clear_run;
  logic [15:0]    avoid_ticks;
  logic           hard_right;

  // Frame reports still owed by the DUT, oldest first.
  lrom_pkg::out_word_t report_q[$];
  int                  fail_count = 0;
  int                  sent_words = 0;

  // Sender pacing: words go out in bursts, separated by random gaps.
  int          burst_left = 0;
  bit          gaps_on    = 1'b1;

  function automatic logic [11:0] bump_tally(logic [11:0] c);
    return (c == TALLY_MAX) ? c : c + 12'd1;
  endfunction

  // Count one point: distance gate first, then the three inclusive boxes.
  function automatic void tally_point(int x, int y);
    longint r2;
    longint lim2;
    int     fl;
    int     fw;
    int     sl;
    int     sw;
    r2   = longint'(x) * x + longint'(y) * y;
    lim2 = longint'(roi_cfg.dist_limit_cm) * longint'(roi_cfg.dist_limit_cm);
    fl   = int'(roi_cfg.front_length_cm);
    fw   = int'(roi_cfg.front_half_width_cm);
    sl   = int'(roi_cfg.side_length_cm);
    sw   = int'(roi_cfg.side_width_cm);
    if (r2 > lim2)
      return;
    if (x >= 0 && x <= fl && y >= -fw && y <= fw)
      front_tally = bump_tally(front_tally);
    // A point on the center line lands in both side boxes.
    if (x >= 0 && x <= sl && y >= 0 && y <= sw)
      left_tally = bump_tally(left_tally);
    if (x >= 0 && x <= sl && y >= -sw && y <= 0)
      right_tally = bump_tally(right_tally);
  endfunction

  // Step the mode machine at a frame end and build the report it produces.
  function automatic lrom_pkg::out_word_t frame_report();
    logic                fb;
    logic                lb;
    logic                rb;
    logic                all_clear;
    lrom_pkg::out_word_t r;
    fb = front_tally >= roi_cfg.block_count;
    lb = left_tally  >= roi_cfg.block_count;
    rb = right_tally >= roi_cfg.block_count;
    all_clear = front_tally <= roi_cfg.release_count &&
                left_tally  <= roi_cfg.release_count &&
                right_tally <= roi_cfg.release_count;
    if (mode_now == lrom_pkg::MODE_TRACK) begin
      // Front wins, then left; both steer right. Only a right block steers left.
      if (fb || lb || rb) begin
        mode_now    = (fb || lb) ? lrom_pkg::MODE_AVOID_RIGHT : lrom_pkg::MODE_AVOID_LEFT;
        hard_right  = fb;
        clear_run   = '0;
        avoid_ticks = '0;
      end
    end else begin
      if (all_clear)
        clear_run = (clear_run == 8'hFF) ? clear_run : clear_run + 8'd1;
      else
        clear_run = '0;
      if (clear_run >= CLEAR_RUN_TO_EXIT || avoid_ticks >= roi_cfg.timeout_ticks)
        mode_now = lrom_pkg::MODE_TRACK;
    end
    r.mode        = mode_now;
    r.steer_milli = lrom_pkg::STEER_NONE;
    if (mode_now != lrom_pkg::MODE_TRACK) begin
      if (hard_right) begin
        r.steer_milli = lrom_pkg::STEER_HARD_RIGHT;
        hard_right    = 1'b0;
      end else begin
        r.steer_milli = (mode_now == lrom_pkg::MODE_AVOID_LEFT) ?
                        lrom_pkg::STEER_LEFT : lrom_pkg::STEER_RIGHT;
      end
    end
    r.front_count = front_tally;
    r.left_count  = left_tally;
    r.right_count = right_tally;
    return r;
  endfunction

  // Apply one accepted input word to the predictor.
  function automatic void apply_word(lrom_pkg::in_word_t w);
    lrom_pkg::out_word_t rpt;
    case (w.operation)
      lrom_pkg::OP_SCAN_START: begin
        front_tally = '0;
        left_tally  = '0;
        right_tally = '0;
      end
      lrom_pkg::OP_POINT: tally_point($signed(w.point_x_cm), $signed(w.point_y_cm));
      lrom_pkg::OP_FRAME_END: begin
        rpt      = frame_report();
        report_q = {report_q, rpt};
      end
      lrom_pkg::OP_TICK: if (avoid_ticks != 16'hFFFF) avoid_ticks = avoid_ticks + 16'd1;
      default: ;
    endcase
  endfunction

  // Mirror a register write; bits above the register width drop off.
  function automatic void store_reg(logic [2:0] idx, logic [15:0] d);
    case (idx)
      lrom_pkg::REG_DIST_LIMIT:   roi_cfg.dist_limit_cm       = d[14:0];
      lrom_pkg::REG_FRONT_LENGTH: roi_cfg.front_length_cm     = d[14:0];
      lrom_pkg::REG_FRONT_HALF_W: roi_cfg.front_half_width_cm = d[14:0];
      lrom_pkg::REG_SIDE_LENGTH:  roi_cfg.side_length_cm      = d[14:0];
      lrom_pkg::REG_SIDE_WIDTH:   roi_cfg.side_width_cm       = d[14:0];
      lrom_pkg::REG_BLOCK_COUNT:  roi_cfg.block_count         = d[11:0];
      lrom_pkg::REG_RELEASE_CNT:  roi_cfg.release_count       = d[11:0];
      lrom_pkg::REG_TIMEOUT:      roi_cfg.timeout_ticks       = d;
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Push one word. Entered and left just after a rising edge; push stays high
  // between back-to-back words so it is never lowered and raised in one step.
  task automatic send_word(input logic [1:0] op, input int x, input int y);
    lrom_pkg::in_word_t w;
    int                 gap;
    w.operation  = op;
    w.point_x_cm = x[15:0];
    w.point_y_cm = y[15:0];
    if (burst_left == 0) begin
      gap = gaps_on ? $urandom_range(0, 7) : 0;
      if (gap > 0) begin
        in_push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    in_push <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (in_full);
    apply_word(w);
    burst_left--;
    sent_words++;
  endtask

  // Hold valid through one write; the caller lowers it after the last one.
  task automatic write_reg(input logic [2:0] idx, input logic [15:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    store_reg(idx, d);
  endtask

  // Write all eight registers; spare upper data bits carry random junk.
  task automatic load_config(input lrom_pkg::cfg_t c);
    logic [15:0] junk;
    junk = 16'($urandom());
    write_reg(lrom_pkg::REG_DIST_LIMIT,   {junk[15],    c.dist_limit_cm});
    write_reg(lrom_pkg::REG_FRONT_LENGTH, {junk[14],    c.front_length_cm});
    write_reg(lrom_pkg::REG_FRONT_HALF_W, {junk[13],    c.front_half_width_cm});
    write_reg(lrom_pkg::REG_SIDE_LENGTH,  {junk[12],    c.side_length_cm});
    write_reg(lrom_pkg::REG_SIDE_WIDTH,   {junk[11],    c.side_width_cm});
    write_reg(lrom_pkg::REG_BLOCK_COUNT,  {junk[10:7],  c.block_count});
    write_reg(lrom_pkg::REG_RELEASE_CNT,  {junk[6:3],   c.release_count});
    write_reg(lrom_pkg::REG_TIMEOUT,      c.timeout_ticks);
    cfg_valid <= 1'b0;
  endtask

  // Drop push, wait for every owed report, then let quiet words drain.
  task automatic settle();
    in_push <= 1'b0;
    burst_left = 0;
    while (report_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: pop on a pattern of its own and check each report
  // ---------------------------------------------------------------------------
  logic [15:0] pop_pattern = 16'hFFFF;
  int unsigned rx_cycle    = 0;

  function automatic void check_field(string name, logic [11:0] want, logic [11:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    lrom_pkg::out_word_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (report_q.size() == 0) begin
        $error("unexpected report: mode %0d steer %0d", out_word.mode, out_word.steer_milli);
        fail_count++;
      end else begin
        want = report_q.pop_front();
        check_field("mode",        12'(want.mode),        12'(out_word.mode));
        check_field("steer_milli", 12'(want.steer_milli), 12'(out_word.steer_milli));
        check_field("front_count", want.front_count,      out_word.front_count);
        check_field("left_count",  want.left_count,       out_word.left_count);
        check_field("right_count", want.right_count,      out_word.right_count);
      end
    end
    // Swap the stall pattern now and then; one in four is full rate.
    rx_cycle++;
    if (rx_cycle % 64 == 0) begin
      if ($urandom_range(0, 3) == 0)
        pop_pattern = 16'hFFFF;
      else
        pop_pattern = 16'(($urandom() & $urandom()) | (32'h1 << $urandom_range(0, 15)));
    end
    out_pop <= pop_pattern[rx_cycle[3:0]];
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Default registers: box edges, distance gate, hard-right entry, clear exit.
  task automatic test_default_frames();
    send_word(lrom_pkg::OP_SCAN_START, 0, 0);
    send_word(lrom_pkg::OP_FRAME_END, 0, 0);          // track, all tallies zero
    send_word(lrom_pkg::OP_SCAN_START, -1, 77);       // fields ignored outside a point
    send_word(lrom_pkg::OP_POINT, 0, 0);              // origin: all three boxes
    send_word(lrom_pkg::OP_POINT, 250, 0);            // exactly on the distance limit
    send_word(lrom_pkg::OP_POINT, 0, 100);            // front half width edge, left box
    send_word(lrom_pkg::OP_POINT, 0, -100);           // front edge, right box
    send_word(lrom_pkg::OP_POINT, 0, 120);            // left side width edge only
    send_word(lrom_pkg::OP_POINT, 0, -121);           // one past the right box
    send_word(lrom_pkg::OP_POINT, -1, 0);             // behind the sensor
    send_word(lrom_pkg::OP_POINT, 177, 177);          // just past the distance limit
    send_word(lrom_pkg::OP_POINT, 32767, 32767);
    send_word(lrom_pkg::OP_POINT, -32768, -32768);    // largest squares
    send_word(lrom_pkg::OP_POINT, 0, -32768);
    send_word(lrom_pkg::OP_TICK, 5, 5);
    send_word(lrom_pkg::OP_FRAME_END, 0, 0);          // front blocked: hard right
    send_word(lrom_pkg::OP_FRAME_END, 0, 0);          // still blocked, plain right
    send_word(lrom_pkg::OP_SCAN_START, 0, 0);
    send_word(lrom_pkg::OP_FRAME_END, 0, 0);          // clear frames count up to exit
    send_word(lrom_pkg::OP_FRAME_END, 0, 0);
    send_word(lrom_pkg::OP_FRAME_END, 0, 0);
  endtask

  // Left-only and right-only entries, then the timeout exit.
  task automatic test_entry_and_timeout();
    lrom_pkg::cfg_t c;
    c               = lrom_pkg::CFG_RESET;
    c.block_count   = 12'd2;
    c.release_count = 12'd0;
    c.timeout_ticks = 16'd2;
    settle();
    load_config(c);
    send_word(lrom_pkg::OP_SCAN_START, 0, 0);
    send_word(lrom_pkg::OP_POINT, 10, 110);
    send_word(lrom_pkg::OP_POINT, 10, 110);
    send_word(lrom_pkg::OP_FRAME_END, 0, 0);          // left block: avoid right
    send_word(lrom_pkg::OP_TICK, 0, 0);
    send_word(lrom_pkg::OP_TICK, 0, 0);
    send_word(lrom_pkg::OP_FRAME_END, 0, 0);          // blocked, but timer expired
    send_word(lrom_pkg::OP_SCAN_START, 0, 0);
    send_word(lrom_pkg::OP_POINT, 10, -110);
    send_word(lrom_pkg::OP_POINT, 10, -110);
    send_word(lrom_pkg::OP_FRAME_END, 0, 0);          // right block: avoid left
    send_word(lrom_pkg::OP_TICK, 0, 0);
    send_word(lrom_pkg::OP_FRAME_END, 0, 0);          // timer one short: stay
    send_word(lrom_pkg::OP_TICK, 0, 0);
    send_word(lrom_pkg::OP_FRAME_END, 0, 0);
  endtask

  // Point picker: mostly inside the boxes, some on their edges, some anywhere.
  task automatic pick_point(output int x, output int y);
    int fl;
    int fw;
    int sl;
    int sw;
    int lim_cm;
    int reach;
    int span;
    fl     = int'(roi_cfg.front_length_cm);
    fw     = int'(roi_cfg.front_half_width_cm);
    sl     = int'(roi_cfg.side_length_cm);
    sw     = int'(roi_cfg.side_width_cm);
    lim_cm = int'(roi_cfg.dist_limit_cm);
    case ($urandom_range(0, 9))
      0, 1: begin
        x = int'($urandom_range(0, 65535)) - 32768;
        y = int'($urandom_range(0, 65535)) - 32768;
      end
      2, 3: begin
        case ($urandom_range(0, 5))
          0:       x = fl;
          1:       x = fl + 1;
          2:       x = sl;
          3:       x = sl + 1;
          4:       x = lim_cm;
          default: x = -1;
        endcase
        case ($urandom_range(0, 6))
          0:       y = 0;
          1:       y = fw;
          2:       y = -fw;
          3:       y = sw;
          4:       y = -sw;
          5:       y = -(fw + 1);
          default: y = sw + 1;
        endcase
      end
      default: begin
        reach = (fl > sl) ? fl : sl;
        if (reach > lim_cm) reach = lim_cm;
        span = (fw > sw) ? fw : sw;
        if (span > lim_cm) span = lim_cm;
        x = $urandom_range(0, reach);
        y = $urandom_range(0, span);
        if ($urandom_range(0, 1) == 1) y = -y;
      end
    endcase
  endtask

  // One frame: usually a scan start, points mixed with ticks and noise, frame end.
  task automatic send_random_frame();
    int n_pts;
    int x;
    int y;
    int hi;
    if ($urandom_range(0, 9) != 0)
      send_word(lrom_pkg::OP_SCAN_START, $urandom_range(0, 65535), $urandom_range(0, 65535));
    // A quarter of the frames stay light so avoid episodes can end on clear frames.
    if ($urandom_range(0, 3) == 0) begin
      hi = (roi_cfg.release_count > 6) ? 6 : int'(roi_cfg.release_count);
    end else begin
      hi = (roi_cfg.block_count > 8) ? 20 : 2 * int'(roi_cfg.block_count) + 4;
    end
    n_pts = $urandom_range(0, hi);
    repeat (n_pts) begin
      case ($urandom_range(0, 9))
        0: send_word(lrom_pkg::OP_TICK, $urandom_range(0, 65535), $urandom_range(0, 65535));
        1: send_word(2'($urandom_range(0, 3)), $urandom_range(0, 65535),
                     $urandom_range(0, 65535));
        default: begin
          pick_point(x, y);
          send_word(lrom_pkg::OP_POINT, x, y);
        end
      endcase
    end
    repeat ($urandom_range(0, 2)) send_word(lrom_pkg::OP_TICK, 0, 0);
    send_word(lrom_pkg::OP_FRAME_END, $urandom_range(0, 65535), $urandom_range(0, 65535));
  endtask

  // Random frames under several register settings, extremes first.
  task automatic test_random_frames();
    lrom_pkg::cfg_t c;
    int             start;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: c = '{dist_limit_cm: 15'd0, front_length_cm: 15'd0, front_half_width_cm: 15'd0,
                 side_length_cm: 15'd0, side_width_cm: 15'd0, block_count: 12'd1,
                 release_count: 12'd0, timeout_ticks: 16'd0};
        1: c = '{dist_limit_cm: 15'h7FFF, front_length_cm: 15'h7FFF,
                 front_half_width_cm: 15'h7FFF, side_length_cm: 15'h7FFF,
                 side_width_cm: 15'h7FFF, block_count: 12'hFFF,
                 release_count: 12'hFFF, timeout_ticks: 16'hFFFF};
        2: begin
          c.dist_limit_cm       = 15'h7FFF;
          c.front_length_cm     = 15'($urandom_range(0, 500));
          c.front_half_width_cm = 15'($urandom_range(0, 200));
          c.side_length_cm      = 15'($urandom_range(0, 400));
          c.side_width_cm       = 15'($urandom_range(0, 200));
          c.block_count         = 12'd1;
          c.release_count       = 12'd0;
          c.timeout_ticks       = 16'd0;
        end
        default: begin
          c.dist_limit_cm       = 15'($urandom_range(50, 600));
          c.front_length_cm     = 15'($urandom_range(0, 500));
          c.front_half_width_cm = 15'($urandom_range(0, 200));
          c.side_length_cm      = 15'($urandom_range(0, 400));
          c.side_width_cm       = 15'($urandom_range(0, 200));
          c.block_count         = 12'($urandom_range(1, 6));
          c.release_count       = 12'($urandom_range(0, c.block_count));
          c.timeout_ticks       = 16'($urandom_range(0, 30));
        end
      endcase
      settle();
      load_config(c);
      // Every third phase runs the sender flat out.
      gaps_on = (phase % 3 != 2);
      start   = sent_words;
      while (sent_words - start < WORDS_PER_PHASE) send_random_frame();
    end
    gaps_on = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    roi_cfg     = lrom_pkg::CFG_RESET;
    mode_now    = lrom_pkg::MODE_TRACK;
    front_tally = '0;
    left_tally  = '0;
    right_tally = '0;
    clear_run   = '0;
    avoid_ticks = '0;
    hard_right  = 1'b0;

    // Hold reset low, then release it at an edge.
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_default_frames();
    test_entry_and_timeout();
    test_random_frames();
    settle();

    if (fail_count == 0 && report_q.size() == 0) begin
      $display("lidar_roi_avoid_mode_top verification clean");
    end else begin
      $display("lidar_roi_avoid_mode_top verification failed");
    end
    $finish;
  end

  // Watchdog: the slowest legal run ends far sooner than this.
  initial begin
    #4_000_000;
    $display("lidar_roi_avoid_mode_top verification failed");
    $finish;
  end

endmodule
